// ===== rtl/ptsf_pkg.sv =====
// ---------------------------------------------------------------------------
// ptsf_pkg: shared types and constants for the plan tag stream filter
// Holds the mode encoding, the tag characters and the literal lookups.
// ---------------------------------------------------------------------------
package ptsf_pkg;

    // Filter mode, as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_TRYING     = 2'd1,
        MODE_PROCESSING = 2'd2
    } mode_t;

    typedef logic [15:0] char_t;
    typedef logic [2:0]  tag_idx_t;

    // Characters that steer the matchers.
    localparam char_t CH_LT    = 16'h003C;
    localparam char_t CH_GT    = 16'h003E;
    localparam char_t CH_SPACE = 16'h0020;
    localparam char_t CH_TAB   = 16'h0009;

    // Length of "<plan" and index of the last character of "</plan>".
    localparam tag_idx_t START_LEN = 3'd5;
    localparam tag_idx_t END_LAST  = 3'd6;

    // Characters of the start tag prefix "<plan".
    function automatic char_t start_lit(input tag_idx_t idx);
        char_t c;
        case (idx)
            3'd0:    c = 16'h003C;
            3'd1:    c = 16'h0070;
            3'd2:    c = 16'h006C;
            3'd3:    c = 16'h0061;
            3'd4:    c = 16'h006E;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    // Characters of the end tag "</plan>".
    function automatic char_t end_lit(input tag_idx_t idx);
        char_t c;
        case (idx)
            3'd0:    c = 16'h003C;
            3'd1:    c = 16'h002F;
            3'd2:    c = 16'h0070;
            3'd3:    c = 16'h006C;
            3'd4:    c = 16'h0061;
            3'd5:    c = 16'h006E;
            3'd6:    c = 16'h003E;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/plan_tag_stream_filter_top.sv =====
// ---------------------------------------------------------------------------
// plan_tag_stream_filter_top: plan block filter for UTF-16 text
// Marks each code unit as kept or dropped and reports the filter mode,
// recognising "<plan ...>" start tags and "</plan>" end tags.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------
//  s_       | in        | s_valid / s_ready  | s_ch[15:0], s_at_line_start
//  m_       | out       | m_valid / m_ready  | m_keep_char, m_mode[1:0]
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (include_tags)
//
// Each item passes through the input register and then sits in the
// result register; one item is taken per cycle unless the result register stalls.
// The tag state is updated as an item moves from the input register to the
// result register; that single step of compare logic sets the rate.
// A stalled result register holds the input register, which holds s_ready.
// Synchronous active-low reset clears the tag state, include_tags and valids.
module plan_tag_stream_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_ch,
    input  logic        s_at_line_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_keep_char,
    output logic [1:0]  m_mode
);
    import ptsf_pkg::*;

    // Configuration and tag state.
    logic     include_tags_reg;
    mode_t    run_mode_reg, run_mode_next;
    logic     start_matching_reg, start_matching_next;
    tag_idx_t start_index_reg, start_index_next;
    logic     after_end_reg, after_end_next;
    tag_idx_t end_index_reg, end_index_next;

    // Input and result registers.
    logic     in_valid_reg;
    char_t    in_ch_reg;
    logic     in_line_start_reg;
    logic     out_valid_reg;
    logic     out_keep_reg;
    mode_t    out_mode_reg;

    logic     advance;
    logic     keep_next;
    tag_idx_t end_pos;

    // An item moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_tags_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            include_tags_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg         <= s_ch;
            in_line_start_reg <= s_at_line_start;
        end
    end

    // Tag matching for the item in the input register.
    always_comb begin
        run_mode_next       = run_mode_reg;
        start_matching_next = start_matching_reg;
        start_index_next    = start_index_reg;
        after_end_next      = after_end_reg;
        end_index_next      = end_index_reg;
        keep_next           = 1'b1;
        end_pos             = (end_index_reg > END_LAST) ? 3'd0 : end_index_reg;

        if (run_mode_reg == MODE_PROCESSING) begin
            // Streaming end tag match, restarting on '<'.
            if (in_ch_reg == end_lit(end_pos)) begin
                if (end_pos == END_LAST) begin
                    after_end_next      = 1'b1;
                    run_mode_next       = MODE_IDLE;
                    start_matching_next = 1'b0;
                    start_index_next    = 3'd0;
                    end_index_next      = 3'd0;
                    keep_next           = include_tags_reg;
                end else begin
                    end_index_next = end_pos + 3'd1;
                end
            end else begin
                end_index_next = (in_ch_reg == CH_LT) ? 3'd1 : 3'd0;
            end
        end else if (run_mode_reg == MODE_IDLE && !in_line_start_reg &&
                     (!after_end_reg || in_ch_reg == CH_SPACE ||
                      in_ch_reg == CH_TAB)) begin
            // Idle off line start: passes unless a non-blank after an end tag.
            keep_next = 1'b1;
        end else if (!start_matching_reg) begin
            if (in_ch_reg == CH_LT) begin
                start_matching_next = 1'b1;
                start_index_next    = 3'd1;
                run_mode_next       = MODE_TRYING;
                keep_next           = include_tags_reg;
            end
        end else if (start_index_reg < START_LEN) begin
            if (in_ch_reg == start_lit(start_index_reg)) begin
                start_index_next = start_index_reg + 3'd1;
                run_mode_next    = MODE_TRYING;
                keep_next        = include_tags_reg;
            end else begin
                // Mismatch drops the partial start tag.
                run_mode_next       = MODE_IDLE;
                start_matching_next = 1'b0;
                start_index_next    = 3'd0;
                end_index_next      = 3'd0;
                after_end_next      = 1'b0;
            end
        end else if (in_ch_reg == CH_GT) begin
            // Start tag complete: enter the body.
            run_mode_next       = MODE_PROCESSING;
            start_matching_next = 1'b0;
            start_index_next    = 3'd0;
            after_end_next      = 1'b0;
            end_index_next      = 3'd0;
            keep_next           = include_tags_reg;
        end else begin
            // Attribute characters up to '>'.
            run_mode_next = MODE_TRYING;
            keep_next     = include_tags_reg;
        end
    end

    // Tag state advances once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg       <= MODE_IDLE;
            start_matching_reg <= 1'b0;
            start_index_reg    <= 3'd0;
            after_end_reg      <= 1'b0;
            end_index_reg      <= 3'd0;
        end else if (advance) begin
            run_mode_reg       <= run_mode_next;
            start_matching_reg <= start_matching_next;
            start_index_reg    <= start_index_next;
            after_end_reg      <= after_end_next;
            end_index_reg      <= end_index_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_keep_reg <= keep_next;
            out_mode_reg <= run_mode_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_keep_char = out_keep_reg;
    assign m_mode      = out_mode_reg;

`ifndef SYNTHESIS
    // A start match is in progress exactly while trying.
    a_match_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        start_matching_reg == (run_mode_reg == MODE_TRYING))
        else $error("start match flag disagrees with mode");

    // The end matcher only holds progress inside a body.
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_mode_reg != MODE_PROCESSING) |-> (end_index_reg == 3'd0))
        else $error("end index set outside processing mode");

    // A running start match has at least '<' and never overruns the prefix.
    a_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        start_matching_reg |-> (start_index_reg != 3'd0 &&
                                start_index_reg <= START_LEN))
        else $error("start index out of range");

    // A held input item stays held while the result register is blocked.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=>
            (in_valid_reg && $stable(in_ch_reg)))
        else $error("input item lost during stall");
`endif

endmodule
